/* hw/rtl/eeat_pkg.sv */
// eeat_pkg: shared types and constants for the encoder electrical angle tracker
// holds configuration register indexes, widths, reset values and the config struct
// no dependencies
`timescale 1ns / 1ps

package eeat_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 15;
    localparam int ERR_BITS      = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENCODER_MODULUS  = 3'd0,
        REG_ZERO_OFFSET      = 3'd1,
        REG_WRAP_THRESHOLD   = 3'd2,
        REG_POLE_SPAN        = 3'd3,
        REG_ERROR_STEP       = 3'd4,
        REG_ERROR_THRESHOLD  = 3'd5,
        REG_ERROR_RELOAD     = 3'd6,
        REG_POLE_COUNT       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] encoder_modulus;
        logic [13:0] zero_offset;
        logic [13:0] wrap_threshold;
        logic [13:0] pole_span;
        logic [13:0] error_step;
        logic [13:0] error_threshold;
        logic [13:0] error_reload;
        logic [7:0]  pole_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        encoder_modulus: 15'd16384,
        zero_offset:     14'd0,
        wrap_threshold:  14'd4096,
        pole_span:       14'd4096,
        error_step:      14'd0,
        error_threshold: 14'd1,
        error_reload:    14'd1,
        pole_count:      8'd4
    };

endpackage

/* hw/rtl/eeat_step.sv */
// eeat_step: next-state logic for one encoder word
// unwraps the mechanical delta, applies pole wrap, error correction and pole index
// depends on eeat_pkg
`timescale 1ns / 1ps

module eeat_step
    import eeat_pkg::*;
#(
    parameter int ENC_BITS   = 14,
    parameter int ANGLE_BITS = 16,
    parameter int POLE_BITS  = 8
) (
    input  t_cfg                          i_cfg,
    input  logic [ENC_BITS-1:0]           i_mech,
    input  logic [ENC_BITS-1:0]           i_last,
    input  logic signed [ANGLE_BITS-1:0]  i_elec,
    input  logic signed [ERR_BITS-1:0]    i_ferr,
    input  logic [POLE_BITS-1:0]          i_pole,
    output logic signed [ENC_BITS:0]      o_delta,
    output logic signed [ANGLE_BITS-1:0]  o_elec,
    output logic signed [ERR_BITS-1:0]    o_ferr,
    output logic [POLE_BITS-1:0]          o_pole
);

    localparam int XW = ((ENC_BITS > 15) ? ENC_BITS : 15) + 3;
    localparam int SW = ((XW > ANGLE_BITS) ? XW : ANGLE_BITS) + 2;
    localparam int CW = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 2;
    localparam int EW = ERR_BITS + 1;
    localparam int PW = 10;

    logic signed [XW-1:0] d0, d1, mag, half_x, mod_x;
    logic signed [SW-1:0] a0;
    logic signed [ANGLE_BITS-1:0] a1;
    logic signed [CW-1:0] a1_x, th_x, span_x, e2;
    logic signed [ERR_BITS-1:0] f1, f2, step_x, reload_x;
    logic signed [EW-1:0] f1_x, eth_x;
    logic signed [PW-1:0] pc_x, pcnt_x, p;
    logic up, down;

    always_comb begin
        // shortest-path unwrap against half the modulus
        d0     = $signed({{(XW-ENC_BITS){1'b0}}, i_mech}) -
                 $signed({{(XW-ENC_BITS){1'b0}}, i_last});
        mag    = d0[XW-1] ? -d0 : d0;
        half_x = $signed({{(XW-14){1'b0}}, i_cfg.encoder_modulus[14:1]});
        mod_x  = $signed({{(XW-15){1'b0}}, i_cfg.encoder_modulus});
        d1     = d0;
        if (mag > half_x) begin
            d1 = d0[XW-1] ? (d0 + mod_x) : (d0 - mod_x);
        end
        o_delta = d1[ENC_BITS:0];

        // electrical angle wraps in its own width after the add
        a0 = $signed({{(SW-ANGLE_BITS){i_elec[ANGLE_BITS-1]}}, i_elec}) +
             $signed({{(SW-XW){d1[XW-1]}}, d1});
        a1 = a0[ANGLE_BITS-1:0];

        a1_x     = $signed({{(CW-ANGLE_BITS){a1[ANGLE_BITS-1]}}, a1});
        th_x     = $signed({{(CW-14){1'b0}}, i_cfg.wrap_threshold});
        span_x   = $signed({{(CW-14){1'b0}}, i_cfg.pole_span});
        step_x   = $signed({{(ERR_BITS-14){1'b0}}, i_cfg.error_step});
        reload_x = $signed({{(ERR_BITS-14){1'b0}}, i_cfg.error_reload});
        eth_x    = $signed({{(EW-14){1'b0}}, i_cfg.error_threshold});
        pc_x     = $signed({{(PW-POLE_BITS){1'b0}}, i_pole});
        pcnt_x   = $signed({2'b00, i_cfg.pole_count});

        up   = (a1_x > th_x);
        down = (a1_x < -th_x);

        e2   = a1_x;
        f1   = i_ferr;
        f1_x = '0;
        f2   = i_ferr;
        p    = pc_x;

        priority if (up) begin
            e2   = a1_x - span_x;
            f1   = i_ferr + step_x;
            f1_x = $signed({f1[ERR_BITS-1], f1});
            f2   = f1;
            if (f1_x > eth_x) begin
                e2 = e2 + $signed({{(CW-1){1'b0}}, 1'b1});
                f2 = f1 - reload_x;
            end
            p = pc_x + $signed({{(PW-1){1'b0}}, 1'b1});
            if (p >= pcnt_x) begin
                p = p - pcnt_x;
            end
        end else if (down) begin
            e2   = a1_x + span_x;
            f1   = i_ferr - step_x;
            f1_x = $signed({f1[ERR_BITS-1], f1});
            f2   = f1;
            if (f1_x < -eth_x) begin
                e2 = e2 - $signed({{(CW-1){1'b0}}, 1'b1});
                f2 = f1 + reload_x;
            end
            p = pc_x - $signed({{(PW-1){1'b0}}, 1'b1});
            if (p[PW-1]) begin
                p = p + pcnt_x;
            end
        end else begin
            e2 = a1_x;
        end

        o_elec = e2[ANGLE_BITS-1:0];
        o_ferr = f2;
        o_pole = p[POLE_BITS-1:0];
    end

endmodule

/* hw/rtl/encoder_electrical_angle_tracker.sv */
// encoder_electrical_angle_tracker: absolute encoder to electrical angle and pole index
// words pass the input, then the output register; one word per cycle while m_axis_tready
// is high; the offset subtract sits before the input register, the unwrap and wrap logic
// before the output register, where the tracking state is updated as the word moves on
// synchronous active-low reset clears tracking state, valids and loads register defaults
// depends on eeat_pkg and eeat_step
`timescale 1ns / 1ps

module encoder_electrical_angle_tracker
    import eeat_pkg::*;
#(
    parameter int ENC_BITS   = 14,
    parameter int ANGLE_BITS = 16,
    parameter int POLE_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // fields from bit 0: encoder_reading
    input  logic [((ENC_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // fields from bit 0: electrical_angle, pole_index, mechanical_angle, angle_delta
    output logic [((ANGLE_BITS+POLE_BITS+2*ENC_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_F = ANGLE_BITS + POLE_BITS + 2 * ENC_BITS + 1;
    localparam int OUT_W = ((OUT_F + 7) / 8) * 8;
    localparam int DW    = ((ENC_BITS > 14) ? ENC_BITS : 14) + 2;

    t_cfg r_cfg;

    logic                         r_in_valid;
    logic [ENC_BITS-1:0]          r_in_mech;
    logic                         r_out_valid;
    logic [OUT_W-1:0]             r_out_data;

    logic [ENC_BITS-1:0]          r_last;
    logic signed [ANGLE_BITS-1:0] r_elec;
    logic signed [ERR_BITS-1:0]   r_ferr;
    logic [POLE_BITS-1:0]         r_pole;

    logic                         advance;
    logic signed [DW-1:0]         diff0, diff1;
    logic [ENC_BITS-1:0]          n_mech;
    logic signed [ENC_BITS:0]     n_delta;
    logic signed [ANGLE_BITS-1:0] n_elec;
    logic signed [ERR_BITS-1:0]   n_ferr;
    logic [POLE_BITS-1:0]         n_pole;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // offset removal, modulus added back once if negative
    always_comb begin
        diff0 = $signed({{(DW-ENC_BITS){1'b0}}, s_axis_tdata[ENC_BITS-1:0]}) -
                $signed({{(DW-14){1'b0}}, r_cfg.zero_offset});
        diff1 = diff0;
        if (diff0[DW-1]) begin
            diff1 = diff0 + $signed({{(DW-15){1'b0}}, r_cfg.encoder_modulus});
        end
        n_mech = diff1[ENC_BITS-1:0];
    end

    eeat_step #(
        .ENC_BITS   (ENC_BITS),
        .ANGLE_BITS (ANGLE_BITS),
        .POLE_BITS  (POLE_BITS)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_mech  (r_in_mech),
        .i_last  (r_last),
        .i_elec  (r_elec),
        .i_ferr  (r_ferr),
        .i_pole  (r_pole),
        .o_delta (n_delta),
        .o_elec  (n_elec),
        .o_ferr  (n_ferr),
        .o_pole  (n_pole)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ENCODER_MODULUS: r_cfg.encoder_modulus <= i_cfg_data[14:0];
                REG_ZERO_OFFSET:     r_cfg.zero_offset     <= i_cfg_data[13:0];
                REG_WRAP_THRESHOLD:  r_cfg.wrap_threshold  <= i_cfg_data[13:0];
                REG_POLE_SPAN:       r_cfg.pole_span       <= i_cfg_data[13:0];
                REG_ERROR_STEP:      r_cfg.error_step      <= i_cfg_data[13:0];
                REG_ERROR_THRESHOLD: r_cfg.error_threshold <= i_cfg_data[13:0];
                REG_ERROR_RELOAD:    r_cfg.error_reload    <= i_cfg_data[13:0];
                REG_POLE_COUNT:      r_cfg.pole_count      <= i_cfg_data[7:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mech <= n_mech;
        end
    end

    // tracking state moves with the word into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_elec      <= '0;
            r_ferr      <= '0;
            r_pole      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_last      <= r_in_mech;
                r_elec      <= n_elec;
                r_ferr      <= n_ferr;
                r_pole      <= n_pole;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_data <= {{(OUT_W-OUT_F){1'b0}}, n_delta, r_in_mech, n_pole, n_elec};
        end
    end

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for encoder_electrical_angle_tracker
// walks a directed table, then random rotation runs over several register settings,
// and checks every output word against a typed row or bench tracker; depends on eeat_pkg
`timescale 1ns / 1ps

module testbench;
    import eeat_pkg::*;

    // output word fields, packed from the top bit down to bit 0
    typedef struct packed {
        logic [14:0] delta;
        logic [13:0] mech;
        logic [7:0]  pole;
        logic [15:0] elec;
    } angle_word_t;

    typedef enum bit {ROW_READING, ROW_REGISTER} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        t_reg_idx    idx;
        int unsigned value;
        bit          typed;
        angle_word_t want;
    } plan_row_t;

    localparam angle_word_t NO_WORD     = '0;
    localparam int          PLAN_ROWS   = 33;
    localparam int          PHASES      = 12;
    localparam int          PHASE_WORDS = 120;

    // directed table; typed rows hold values that follow directly from reset settings
    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{ROW_READING,  REG_ENCODER_MODULUS, 0,     1'b1, '{15'd0, 14'd0, 8'd0, 16'd0}},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16383, 1'b1,
          '{15'h7fff, 14'd16383, 8'd0, 16'hffff}},
        '{ROW_READING,  REG_ENCODER_MODULUS, 0,     1'b1, '{15'd1, 14'd0, 8'd0, 16'd0}},
        '{ROW_READING,  REG_ENCODER_MODULUS, 8192,  1'b1,
          '{15'h2000, 14'd8192, 8'd1, 16'd4096}},
        '{ROW_READING,  REG_ENCODER_MODULUS, 0,     1'b1,
          '{15'h6000, 14'd0, 8'd1, 16'hf000}},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16383, 1'b1,
          '{15'h7fff, 14'd16383, 8'd0, 16'hffff}},
        // error accumulator with corrections, smallest wrap threshold, widest span
        '{ROW_REGISTER, REG_ERROR_STEP,      3,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_ERROR_THRESHOLD, 4,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_ERROR_RELOAD,    5,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_WRAP_THRESHOLD,  1,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_POLE_SPAN,       16383, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 4000,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 8000,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 12000, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16000, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 3000,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16383, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 8191,  1'b0, NO_WORD},
        // pole counter left out of range by a smaller pole count
        '{ROW_REGISTER, REG_POLE_COUNT,      1,     1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 8192,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 0,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_POLE_COUNT,      255,   1'b0, NO_WORD},
        // smallest modulus, offset and readings past it
        '{ROW_REGISTER, REG_ENCODER_MODULUS, 2,     1'b0, NO_WORD},
        '{ROW_REGISTER, REG_ZERO_OFFSET,     16383, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 0,     1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 1,     1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16383, 1'b0, NO_WORD},
        '{ROW_REGISTER, REG_ENCODER_MODULUS, 16384, 1'b0, NO_WORD},
        '{ROW_REGISTER, REG_ZERO_OFFSET,     9000,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 100,   1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 9000,  1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 16383, 1'b0, NO_WORD},
        '{ROW_READING,  REG_ENCODER_MODULUS, 4000,  1'b0, NO_WORD}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    // bench copy of the tracker state and registers
    t_cfg        cfg_model = CFG_RESET;
    logic [13:0] last_mech = '0;
    int          elec_angle = 0;
    int          frac_err = 0;
    logic [7:0]  pole_idx = '0;

    angle_word_t pending_angles [$];
    angle_word_t want_word;
    angle_word_t got_word;
    bit          steady = 1'b0;
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          settings_used = 1;

    encoder_electrical_angle_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int wrap16(input int v);
        logic signed [15:0] b;
        b = v[15:0];
        return int'(b);
    endfunction

    // advances the bench tracker by one reading and returns the word it should produce
    function automatic angle_word_t track_angle(input logic [13:0] reading);
        int          modulus;
        int          diff;
        int          delta;
        int          mag;
        int          wrap_th;
        int          p;
        logic [13:0] mech;
        angle_word_t w;
        modulus = int'(cfg_model.encoder_modulus);
        wrap_th = int'(cfg_model.wrap_threshold);
        diff = int'(reading) - int'(cfg_model.zero_offset);
        if (diff < 0) begin
            diff += modulus;
        end
        mech = diff[13:0];
        delta = int'(mech) - int'(last_mech);
        last_mech = mech;
        mag = (delta < 0) ? -delta : delta;
        // shortest path around the revolution
        if (mag > (modulus >>> 1)) begin
            delta += (delta < 0) ? modulus : -modulus;
        end
        elec_angle = wrap16(elec_angle + delta);
        p = int'(pole_idx);
        if (elec_angle > wrap_th) begin
            elec_angle -= int'(cfg_model.pole_span);
            frac_err = wrap16(frac_err + int'(cfg_model.error_step));
            if (frac_err > int'(cfg_model.error_threshold)) begin
                elec_angle += 1;
                frac_err = wrap16(frac_err - int'(cfg_model.error_reload));
            end
            p += 1;
            if (p >= int'(cfg_model.pole_count)) begin
                p -= int'(cfg_model.pole_count);
            end
        end else if (elec_angle < -wrap_th) begin
            elec_angle += int'(cfg_model.pole_span);
            frac_err = wrap16(frac_err - int'(cfg_model.error_step));
            if (frac_err < -int'(cfg_model.error_threshold)) begin
                elec_angle -= 1;
                frac_err = wrap16(frac_err + int'(cfg_model.error_reload));
            end
            p -= 1;
            if (p < 0) begin
                p += int'(cfg_model.pole_count);
            end
        end
        elec_angle = wrap16(elec_angle);
        pole_idx = p[7:0];
        w.elec = elec_angle[15:0];
        w.pole = pole_idx;
        w.mech = mech;
        w.delta = delta[14:0];
        return w;
    endfunction

    function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
                                               input int phase);
        int unsigned r;
        r = $urandom_range(9);
        if (phase == 0 || (phase > 1 && r < 2)) begin
            return lo;
        end
        if (phase == 1 || r < 4) begin
            return hi;
        end
        return $urandom_range(hi, lo);
    endfunction

    task automatic push_reading(input logic [13:0] r, input bit typed,
                                input angle_word_t typed_word);
        angle_word_t w;
        while (!steady && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, r};
        do @(posedge i_clk); while (!s_axis_tready);
        w = track_angle(r);
        pending_angles.push_back(typed ? typed_word : w);
        words_sent++;
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[14:0];
        case (idx)
            REG_ENCODER_MODULUS: cfg_model.encoder_modulus = value[14:0];
            REG_ZERO_OFFSET:     cfg_model.zero_offset = value[13:0];
            REG_WRAP_THRESHOLD:  cfg_model.wrap_threshold = value[13:0];
            REG_POLE_SPAN:       cfg_model.pole_span = value[13:0];
            REG_ERROR_STEP:      cfg_model.error_step = value[13:0];
            REG_ERROR_THRESHOLD: cfg_model.error_threshold = value[13:0];
            REG_ERROR_RELOAD:    cfg_model.error_reload = value[13:0];
            REG_POLE_COUNT:      cfg_model.pole_count = value[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word = angle_word_t'(m_axis_tdata[52:0]);
            if (pending_angles.size() == 0) begin
                $display("%0t: output word with none pending, got %h", $time, got_word);
                errors++;
            end else begin
                want_word = pending_angles.pop_front();
                if (got_word.elec !== want_word.elec) begin
                    $display("%0t: electrical_angle expected %0d got %0d", $time,
                             $signed(want_word.elec), $signed(got_word.elec));
                    errors++;
                end
                if (got_word.pole !== want_word.pole) begin
                    $display("%0t: pole_index expected %0d got %0d", $time,
                             want_word.pole, got_word.pole);
                    errors++;
                end
                if (got_word.mech !== want_word.mech) begin
                    $display("%0t: mechanical_angle expected %0d got %0d", $time,
                             want_word.mech, got_word.mech);
                    errors++;
                end
                if (got_word.delta !== want_word.delta) begin
                    $display("%0t: angle_delta expected %0d got %0d", $time,
                             $signed(want_word.delta), $signed(got_word.delta));
                    errors++;
                end
            end
            words_checked++;
        end
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d words still pending", pending_angles.size());
        $display("encoder_electrical_angle_tracker test failed");
        $finish;
    end

    initial begin
        int pos;
        int modulus;
        int speed;
        int dir;
        int mag;
        logic [13:0] reading;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REGISTER) begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].value);
                settings_used++;
            end else begin
                push_reading(plan[i].value[13:0], plan[i].typed, plan[i].want);
            end
        end

        // random rotation runs; first phase at all low limits, second at all high limits
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(REG_ENCODER_MODULUS, pick_value(2, 16384, ph));
            write_reg(REG_ZERO_OFFSET, pick_value(0, 16383, ph));
            write_reg(REG_WRAP_THRESHOLD, pick_value(1, 16383, ph));
            write_reg(REG_POLE_SPAN, pick_value(1, 16383, ph));
            write_reg(REG_ERROR_STEP, pick_value(0, 16383, ph));
            write_reg(REG_ERROR_THRESHOLD, pick_value(0, 16383, ph));
            write_reg(REG_ERROR_RELOAD, pick_value(0, 16383, ph));
            write_reg(REG_POLE_COUNT, pick_value(1, 255, ph));
            settings_used++;
            steady = (ph == 4);
            modulus = int'(cfg_model.encoder_modulus);
            case ($urandom_range(2))
                0:       speed = $urandom_range(16, 1);
                1:       speed = $urandom_range(modulus / 8 + 1, 1);
                default: speed = $urandom_range(modulus / 2 + 1, 1);
            endcase
            dir = $urandom_range(1) ? 1 : -1;
            pos = $urandom_range(modulus - 1);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // hold off once mid-run until the pipeline has emptied
                if (ph == 6 && k == PHASE_WORDS / 2) begin
                    wait_drained();
                end
                mag = $urandom_range(speed, 0);
                pos += ($urandom_range(9) < 8) ? dir * mag : -dir * mag;
                pos = ((pos % modulus) + modulus) % modulus;
                if ($urandom_range(99) < 15) begin
                    reading = 14'($urandom_range(16383));
                end else begin
                    reading = pos[13:0];
                end
                push_reading(reading, 1'b0, NO_WORD);
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("sent %0d encoder words under %0d register settings, checked %0d outputs",
                 words_sent, settings_used, words_checked);
        if (errors == 0) begin
            $display("encoder_electrical_angle_tracker test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("encoder_electrical_angle_tracker test failed");
        end
        $finish;
    end

endmodule
